// ===== hdl/twws_pkg.sv =====
// Shared types, op codes and a popcount helper for the timing wheel wakeup scheduler.
`default_nettype none

package twws_pkg;

  localparam logic OP_REGISTER = 1'b0;
  localparam logic OP_SERVICE  = 1'b1;

  typedef struct packed {
    logic        op;
    logic [5:0]  agent_id;
    logic [31:0] cycle;
  } req_t;

  typedef struct packed {
    logic [63:0] woken_mask;
    logic [6:0]  woken_count;
    logic        wheel_empty;
    logic [7:0]  next_distance;
    logic [31:0] next_cycle;
  } rsp_t;

  // byte-wise partial counts, then a short sum over the eight bytes
  function automatic logic [6:0] popcount64(input logic [63:0] v);
    logic [3:0] part [8];
    logic [6:0] sum;
    for (int b = 0; b < 8; b++) begin
      part[b] = '0;
      for (int i = 0; i < 8; i++) begin
        part[b] = part[b] + 4'(v[8*b+i]);
      end
    end
    sum = '0;
    for (int b = 0; b < 8; b++) begin
      sum = sum + 7'(part[b]);
    end
    return sum;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/timing_wheel_wakeup_scheduler.sv =====
// Timing wheel wakeup scheduler: slot mask memory, occupancy bitmap, next-slot search.
//
//  channel | signals                 | dir | transfer
//  --------+-------------------------+-----+-------------------------------------
//  request | start_i, busy_o, req_i  | in  | edge with start_i high, busy_o low
//  result  | done_o, rsp_o           | out | edge ending the cycle done_o is high
//
// One item per clock; busy_o stays low. Each item passes through the input register,
// reciprocal multiply, slot index fixup, mask memory read and update/search into the
// result register. Register items give no strobe. Reset clears the occupancy bitmap
// and the valid flags; a slot whose occupancy bit is clear reads as an empty mask, so
// the mask memory needs no reset. The receiver cannot stall; results are never held.
`default_nettype none

module timing_wheel_wakeup_scheduler #(
  parameter int NUM_SLOTS  = 128,
  parameter int NUM_AGENTS = 64
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            start_i,
  output logic                 busy_o,
  input  wire twws_pkg::req_t  req_i,
  output logic                 done_o,
  output twws_pkg::rsp_t       rsp_o
);

  localparam int SLOT_W  = (NUM_SLOTS > 2) ? $clog2(NUM_SLOTS) : 1;
  localparam int DIST_W  = SLOT_W + 1;
  localparam int SH      = 32 + SLOT_W;
  localparam int RECIP_W = 34;
  localparam logic [RECIP_W-1:0] RECIP =
      RECIP_W'((64'd1 << SH) / 64'(NUM_SLOTS));

  // ---------------- front pipeline: slot = cycle mod NUM_SLOTS ----------------
  logic                 s0_vld_q, s1_vld_q, s2_vld_q, s3_vld_q;
  twws_pkg::req_t       s0_req_q, s1_req_q, s2_req_q, s3_req_q;
  logic [31:0]          s1_quo_q;
  logic [SLOT_W-1:0]    s2_cur_q, s3_cur_q;

  logic [65:0]          prod;
  logic [31:0]          quo_est;
  logic [31:0]          rem_full;
  logic [DIST_W-1:0]    rem;
  logic [SLOT_W-1:0]    cur_d;

  assign busy_o  = 1'b0;
  assign prod    = 66'(s0_req_q.cycle) * 66'(RECIP);
  assign quo_est = 32'(prod >> SH);

  // estimate is low by at most one, so one compare and subtract fixes it
  assign rem_full = s1_req_q.cycle - 32'(s1_quo_q * 32'(NUM_SLOTS));
  assign rem      = rem_full[DIST_W-1:0];
  assign cur_d    = (rem >= DIST_W'(NUM_SLOTS)) ? SLOT_W'(rem - DIST_W'(NUM_SLOTS))
                                                : SLOT_W'(rem);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_vld_q <= 1'b0;
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      s3_vld_q <= 1'b0;
    end else begin
      s0_vld_q <= start_i && !busy_o;
      s1_vld_q <= s0_vld_q;
      s2_vld_q <= s1_vld_q;
      s3_vld_q <= s2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s0_req_q <= req_i;
    s1_req_q <= s0_req_q;
    s1_quo_q <= quo_est;
    s2_req_q <= s1_req_q;
    s2_cur_q <= cur_d;
    s3_req_q <= s2_req_q;
    s3_cur_q <= s2_cur_q;
  end

  // ---------------- slot mask memory ----------------
  logic [NUM_AGENTS-1:0] mem [NUM_SLOTS];
  logic [NUM_AGENTS-1:0] rdata_q;
  logic                  wr_en;
  logic [NUM_AGENTS-1:0] wr_data;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[s3_cur_q] <= wr_data;
    end
    rdata_q <= mem[s2_cur_q];
  end

  // last write, forwarded to the next item when it hits the same slot
  logic                  wr_vld_q;
  logic [SLOT_W-1:0]     wr_addr_q;
  logic [NUM_AGENTS-1:0] wr_data_q;
  logic [NUM_SLOTS-1:0]  act_q, act_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_vld_q   <= 1'b0;
      act_q      <= '0;
    end else begin
      wr_vld_q <= wr_en;
      act_q    <= act_d;
    end
  end

  always_ff @(posedge clk_i) begin
    wr_addr_q <= s3_cur_q;
    wr_data_q <= wr_data;
  end

  // ---------------- update and next-slot search ----------------
  function automatic logic [SLOT_W-1:0] first_set(input logic [NUM_SLOTS-1:0] v);
    logic [SLOT_W-1:0] idx;
    idx = '0;
    for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
      if (v[i]) begin
        idx = SLOT_W'(i);
      end
    end
    return idx;
  endfunction

  logic                  hit;
  logic [NUM_AGENTS-1:0] base;
  logic [NUM_AGENTS-1:0] agent_bit;
  logic                  agent_ok;
  logic                  is_svc;
  logic [NUM_SLOTS-1:0]  cur_bit;
  logic [NUM_SLOTS-1:0]  above;
  logic [SLOT_W-1:0]     first_hi, first_lo;
  logic [DIST_W-1:0]     next_dist;
  logic                  empty;

  // a slot holds a nonzero mask exactly when its occupancy bit is set
  assign hit      = wr_vld_q && (wr_addr_q == s3_cur_q);
  assign base     = hit ? wr_data_q : (act_q[s3_cur_q] ? rdata_q : '0);
  assign agent_ok = {1'b0, s3_req_q.agent_id} < 7'(NUM_AGENTS);
  assign is_svc   = (s3_req_q.op == twws_pkg::OP_SERVICE);
  assign wr_en    = s3_vld_q && (is_svc || agent_ok);
  assign wr_data  = is_svc ? '0 : (base | agent_bit);

  always_comb begin
    for (int i = 0; i < NUM_AGENTS; i++) begin
      agent_bit[i] = (s3_req_q.agent_id == 6'(i));
    end
    for (int i = 0; i < NUM_SLOTS; i++) begin
      cur_bit[i] = (s3_cur_q == SLOT_W'(i));
    end
  end

  always_comb begin
    act_d = act_q;
    if (s3_vld_q) begin
      if (is_svc) begin
        act_d = act_q & ~cur_bit;
      end else if (agent_ok) begin
        act_d = act_q | cur_bit;
      end
    end
  end

  always_comb begin
    for (int i = 0; i < NUM_SLOTS; i++) begin
      above[i] = act_d[i] && (SLOT_W'(i) > s3_cur_q);
    end
  end

  assign first_hi = first_set(above);
  assign first_lo = first_set(act_d);
  assign empty    = ~|act_d;

  // next active slot after the current one, else wrap to the lowest one; one if empty
  always_comb begin
    if (|above) begin
      next_dist = DIST_W'(first_hi) - DIST_W'(s3_cur_q);
    end else if (!empty) begin
      next_dist = DIST_W'(first_lo) + DIST_W'(NUM_SLOTS) - DIST_W'(s3_cur_q);
    end else begin
      next_dist = DIST_W'(1);
    end
  end

  // ---------------- result register ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_o <= 1'b0;
    end else begin
      done_o <= s3_vld_q && is_svc;
    end
  end

  always_ff @(posedge clk_i) begin
    rsp_o.woken_mask    <= 64'(base);
    rsp_o.woken_count   <= twws_pkg::popcount64(64'(base));
    rsp_o.wheel_empty   <= empty;
    rsp_o.next_distance <= 8'(next_dist);
    rsp_o.next_cycle    <= s3_req_q.cycle + 32'(next_dist);
  end

  // ---------------- assertions ----------------
  a_strobe_follows_service: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i && (req_i.op == twws_pkg::OP_SERVICE), 5))
    else $error("result strobe without a service transfer five cycles earlier");

  a_empty_distance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && rsp_o.wheel_empty) |-> (rsp_o.next_distance == 8'd1))
    else $error("empty wheel must report a distance of one");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (rsp_o.woken_count <= 7'(NUM_AGENTS)))
    else $error("woken count exceeds the number of agents");

endmodule

`default_nettype wire
